// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/dtst_pkg.sv -----
// types, codes and helpers of the deadline timer slot table
// no dependencies
`default_nettype none
package dtst_pkg;
   localparam int SLOT_COUNT_DEF = 16;
   localparam int MAX_RESULTS    = 16;
   localparam int FIRE_W         = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      CMD_ARM_ONE = 3'd0,
      CMD_ARM_REC = 3'd1,
      CMD_CANCEL  = 3'd2,
      CMD_TICK    = 3'd3,
      CMD_START   = 3'd4,
      CMD_STOP    = 3'd5
   } cmd_type;

   localparam logic [1:0] KIND_ARM    = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;
   localparam logic [1:0] KIND_ACK    = 2'd3;

   typedef struct packed {
      logic [31:0] handle;
      logic [63:0] deadline;
      logic [63:0] period;
      logic [31:0] tag;
      logic [31:0] arg;
   } slot_type;

   typedef struct packed {
      logic is_free;
      logic due;
      logic match;
      logic pended;
   } cell_stat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] handle;
      logic        success;
      logic [31:0] tag;
      logic [31:0] arg;
   } resp_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/dtst_cell.sv -----
// one timer slot of the rotating chain, with its own status flags
// depends on dtst_pkg
`default_nettype none
module dtst_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift_en,
   input  wire dtst_pkg::slot_type     slot_d,
   input  wire logic [63:0]            now,
   input  wire logic [31:0]            hid,
   output dtst_pkg::slot_type          slot_q,
   output dtst_pkg::cell_stat_type     stat
);
   import dtst_pkg::*;

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (shift_en) begin
         slot_ff <= slot_d;
      end
   end

   assign slot_q       = slot_ff;
   assign stat.is_free = (slot_ff.handle == 32'd0);
   assign stat.due     = (slot_ff.handle != 32'd0) && (slot_ff.deadline <= now);
   assign stat.match   = (hid != 32'd0) && (slot_ff.handle == hid);
   assign stat.pended  = (slot_ff.handle != 32'd0) && (slot_ff.period != 64'd0) &&
                         (slot_ff.deadline == 64'd0);
endmodule
`default_nettype wire

// ----- rtl/dtst_rem_div.sv -----
// bit-serial remainder unit for the recurring period skip, one bit a cycle
// depends on nothing outside this file
`default_nettype none
module dtst_rem_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      rem
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  step_ff, step_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [64:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[63]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 64'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[63:0];
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

// ----- rtl/deadline_timer_slot_table_unit.sv -----
// top level of the deadline timer slot table: command control, slot ring, reply buffer
// depends on dtst_pkg, dtst_cell, dtst_rem_div and assert_macros.svh
// The slots sit in a ring of SLOT_COUNT cells that rotates one place per cycle past a
// single head stage during a walk unless the walk is held; arm, cancel, start and a tick
// while running walk the table in index order; stop, a tick while stopped and an
// unknown command do not walk it. On a tick each due recurring slot waits for the
// bit-serial remainder of its period skip. A fired word waits in a pending register so
// that the final one can carry last_of_run; a stalled result side holds the walk of a
// tick. No item is accepted while a command is being worked on.
`default_nettype none
`include "assert_macros.svh"
module deadline_timer_slot_table_unit #(
   parameter int SLOT_COUNT = dtst_pkg::SLOT_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [63:0] req_time_value,
   input  wire logic [31:0] req_handle_id,
   input  wire logic [63:0] req_cur_time,
   input  wire logic [31:0] req_callback_tag,
   input  wire logic [31:0] req_callback_arg,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_reply_kind,
   output logic [31:0]      rsp_handle_out,
   output logic             rsp_success,
   output logic [31:0]      rsp_fired_tag,
   output logic [31:0]      rsp_fired_arg,
   output logic             rsp_last_of_run
);
   import dtst_pkg::*;

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   typedef enum logic [2:0] {S_IDLE, S_WALK, S_DIV, S_REPLY, S_FINISH} state_type;

   state_type         state_ff;
   logic [2:0]        cmd_ff;
   logic [63:0]       tv_ff, now_ff;
   logic [31:0]       hid_ff, tag_ff, arg_ff;
   logic [IW-1:0]     idx_ff;
   logic [FIRE_W-1:0] fired_ff;
   logic              done_ff, arm_ok_ff, start_act_ff, running_ff;
   logic [31:0]       counter_ff, handle_ff;
   resp_type          pend_ff;
   logic              pend_valid_ff;
   resp_type          out_ff;
   logic              out_valid_ff, out_last_ff;

   slot_type          slot_q [SLOT_COUNT];
   cell_stat_type     stat   [SLOT_COUNT];
   slot_type          head, head_in;
   cell_stat_type     hst;
   logic              rotate, emit, div_start, arm_take, cancel_hit;
   logic              out_free, can_emit, move_pend, walk_end;
   logic [31:0]       new_handle;
   logic [63:0]       new_deadline;
   logic              div_done;
   logic [63:0]       div_rem;

   assign head = slot_q[0];
   assign hst  = stat[0];

   for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
      slot_type d;
      if (k == SLOT_COUNT - 1) begin : g_tail
         assign d = head_in;
      end else begin : g_mid
         assign d = slot_q[k+1];
      end
      dtst_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (rotate),
         .slot_d   (d),
         .now      (now_ff),
         .hid      (hid_ff),
         .slot_q   (slot_q[k]),
         .stat     (stat[k])
      );
   end

   dtst_rem_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (now_ff - head.deadline),
      .divisor  (head.period),
      .done     (div_done),
      .rem      (div_rem)
   );

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign can_emit   = !pend_valid_ff || out_free;
   assign new_handle = (counter_ff == 32'd0) ? 32'd1 : counter_ff;
   assign new_deadline = (cmd_ff == CMD_ARM_REC) ?
                         (running_ff ? sat_add(now_ff, tv_ff) : 64'd0) : tv_ff;
   assign walk_end   = rotate && (idx_ff == IW'(SLOT_COUNT - 1));

   always_comb begin
      head_in    = head;
      rotate     = 1'b0;
      emit       = 1'b0;
      div_start  = 1'b0;
      arm_take   = 1'b0;
      cancel_hit = 1'b0;
      case (state_ff)
         S_WALK: begin
            case (cmd_ff)
               CMD_ARM_ONE, CMD_ARM_REC: begin
                  rotate = 1'b1;
                  if (arm_ok_ff && !done_ff && hst.is_free) begin
                     arm_take         = 1'b1;
                     head_in.handle   = new_handle;
                     head_in.deadline = new_deadline;
                     head_in.period   = (cmd_ff == CMD_ARM_REC) ? tv_ff : 64'd0;
                     head_in.tag      = tag_ff;
                     head_in.arg      = arg_ff;
                  end
               end
               CMD_CANCEL: begin
                  rotate = 1'b1;
                  if (!done_ff && hst.match) begin
                     cancel_hit = 1'b1;
                     head_in    = '0;
                  end
               end
               CMD_START: begin
                  rotate = 1'b1;
                  if (start_act_ff && hst.pended) begin
                     head_in.deadline = sat_add(now_ff, head.period);
                  end
               end
               CMD_TICK: begin
                  if (hst.due && (fired_ff < FIRE_W'(MAX_RESULTS))) begin
                     if (can_emit) begin
                        emit = 1'b1;
                        if (head.period == 64'd0) begin
                           head_in = '0;
                           rotate  = 1'b1;
                        end else begin
                           div_start = 1'b1;
                        end
                     end
                  end else begin
                     rotate = 1'b1;
                  end
               end
               default: rotate = 1'b1;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               rotate           = 1'b1;
               head_in.deadline = sat_add(now_ff - div_rem, head.period);
            end
         end
         default: ;
      endcase
      move_pend = pend_valid_ff &&
                  ((state_ff == S_WALK && emit) || (state_ff == S_FINISH && out_free));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         running_ff    <= 1'b0;
         counter_ff    <= 32'd1;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         fired_ff      <= '0;
      end else begin
         if (out_free) begin
            out_valid_ff <= move_pend;
         end
         if (move_pend) begin
            out_ff      <= pend_ff;
            out_last_ff <= (state_ff == S_FINISH);
         end
         if (arm_take) begin
            counter_ff <= new_handle + 32'd1;
            handle_ff  <= new_handle;
         end
         if (arm_take || cancel_hit) begin
            done_ff <= 1'b1;
         end
         if (emit) begin
            pend_ff       <= '{KIND_FIRED, head.handle, 1'b0, head.tag, head.arg};
            pend_valid_ff <= 1'b1;
            fired_ff      <= fired_ff + FIRE_W'(1);
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff       <= req_cmd;
                  tv_ff        <= req_time_value;
                  hid_ff       <= req_handle_id;
                  now_ff       <= req_cur_time;
                  tag_ff       <= req_callback_tag;
                  arg_ff       <= req_callback_arg;
                  idx_ff       <= '0;
                  fired_ff     <= '0;
                  done_ff      <= 1'b0;
                  arm_ok_ff    <= (req_callback_tag != 32'd0) &&
                                  !(req_cmd == CMD_ARM_REC && req_time_value == 64'd0);
                  start_act_ff <= !running_ff;
                  case (req_cmd)
                     CMD_ARM_ONE, CMD_ARM_REC, CMD_CANCEL: state_ff <= S_WALK;
                     CMD_START: begin
                        running_ff <= 1'b1;
                        state_ff   <= S_WALK;
                     end
                     CMD_TICK: state_ff <= running_ff ? S_WALK : S_IDLE;
                     CMD_STOP: begin
                        running_ff    <= 1'b0;
                        pend_ff       <= '{KIND_ACK, 32'd0, 1'b0, 32'd0, 32'd0};
                        pend_valid_ff <= 1'b1;
                        state_ff      <= S_FINISH;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_WALK, S_DIV: begin
               if (rotate) begin
                  idx_ff <= idx_ff + IW'(1);
               end
               if (walk_end) begin
                  state_ff <= (cmd_ff == CMD_TICK) ? S_FINISH : S_REPLY;
               end else if (div_start) begin
                  state_ff <= S_DIV;
               end else if (rotate) begin
                  state_ff <= S_WALK;
               end
            end
            S_REPLY: begin
               pend_valid_ff <= 1'b1;
               case (cmd_ff)
                  CMD_CANCEL: pend_ff <= '{KIND_CANCEL, 32'd0, done_ff, 32'd0, 32'd0};
                  CMD_START:  pend_ff <= '{KIND_ACK, 32'd0, 1'b0, 32'd0, 32'd0};
                  default: begin
                     pend_ff <= '{KIND_ARM, done_ff ? handle_ff : 32'd0, done_ff,
                                  32'd0, 32'd0};
                  end
               endcase
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (!pend_valid_ff || out_free) begin
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_reply_kind  = out_ff.kind;
   assign rsp_handle_out  = out_ff.handle;
   assign rsp_success     = out_ff.success;
   assign rsp_fired_tag   = out_ff.tag;
   assign rsp_fired_arg   = out_ff.arg;
   assign rsp_last_of_run = out_last_ff;

   `ASSERT_PROP(a_idle_no_pend, clock, reset,
      (state_ff == S_IDLE) |-> !pend_valid_ff, "pending word left behind at idle")
   `ASSERT_PROP(a_div_recurring, clock, reset,
      (state_ff == S_DIV) |-> (head.period != 64'd0 && head.handle != 32'd0),
      "remainder unit busy on a non-recurring head")
   `ASSERT_PROP(a_div_done_state, clock, reset,
      div_done |-> (state_ff == S_DIV), "remainder done outside its wait")
   `ASSERT_PROP(a_fire_limit, clock, reset,
      fired_ff <= FIRE_W'(MAX_RESULTS), "more fired words than allowed per tick")
endmodule
`default_nettype wire

// ----- sim/deadline_timer_slot_table_unit_test.sv -----
// testbench of the deadline timer slot table: random and directed commands, reply check
// depends on dtst_pkg and deadline_timer_slot_table_unit
`timescale 1ns / 1ps
`default_nettype none
module deadline_timer_slot_table_unit_test;
   import dtst_pkg::*;

   localparam int NSLOT = 16;
   localparam logic [63:0] U64_MAX = {64{1'b1}};

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] time_value;
      logic [31:0] handle_id;
      logic [63:0] cur_time;
      logic [31:0] tag;
      logic [31:0] arg;
   } command_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] handle;
      logic        success;
      logic [31:0] tag;
      logic [31:0] arg;
      logic        last;
   } reply_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [2:0] req_cmd;
   logic [63:0] req_time_value, req_cur_time;
   logic [31:0] req_handle_id, req_callback_tag, req_callback_arg;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_reply_kind;
   logic [31:0] rsp_handle_out, rsp_fired_tag, rsp_fired_arg;
   logic rsp_success, rsp_last_of_run;

   deadline_timer_slot_table_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_time_value(req_time_value), .req_handle_id(req_handle_id),
      .req_cur_time(req_cur_time), .req_callback_tag(req_callback_tag),
      .req_callback_arg(req_callback_arg),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_reply_kind(rsp_reply_kind),
      .rsp_handle_out(rsp_handle_out), .rsp_success(rsp_success),
      .rsp_fired_tag(rsp_fired_tag), .rsp_fired_arg(rsp_fired_arg),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // predicted table state
   logic [31:0] tbl_handle[NSLOT];
   logic [63:0] tbl_deadline[NSLOT];
   logic [63:0] tbl_period[NSLOT];
   logic [31:0] tbl_tag[NSLOT];
   logic [31:0] tbl_arg[NSLOT];
   logic [31:0] next_handle;
   logic        table_running;

   command_type pending_cmds[$];
   reply_type   expected_replies[$];
   int  error_count = 0;
   bit  hold_sender = 0;
   int  idle_pct = 33;
   logic [31:0] issued[$];

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? U64_MAX : s[63:0];
   endfunction

   function automatic reply_type make_reply(logic [1:0] k, logic [31:0] h, logic ok,
                                            logic [31:0] t, logic [31:0] a);
      reply_type r;
      r.kind = k; r.handle = h; r.success = ok; r.tag = t; r.arg = a; r.last = 0;
      return r;
   endfunction

   task automatic clear_entry(int i);
      tbl_handle[i] = 0; tbl_deadline[i] = 0; tbl_period[i] = 0;
      tbl_tag[i] = 0; tbl_arg[i] = 0;
   endtask

   task automatic predict_replies(command_type c);
      reply_type outs[$];
      int slot;
      logic ok;
      logic [31:0] h;
      logic [63:0] base;
      slot = -1;
      ok = 0;
      h = 0;
      case (c.cmd)
         CMD_ARM_ONE, CMD_ARM_REC: begin
            if (c.tag != 0 && !(c.cmd == CMD_ARM_REC && c.time_value == 0)) begin
               for (int i = 0; i < NSLOT; i++)
                  if (slot < 0 && tbl_handle[i] == 0) slot = i;
            end
            if (slot >= 0) begin
               h = next_handle;
               next_handle++;
               if (h == 0) begin
                  h = next_handle;
                  next_handle++;
               end
               tbl_handle[slot] = h;
               tbl_tag[slot] = c.tag;
               tbl_arg[slot] = c.arg;
               if (c.cmd == CMD_ARM_REC) begin
                  tbl_period[slot] = c.time_value;
                  tbl_deadline[slot] = table_running ? add_sat(c.cur_time, c.time_value) : 0;
               end else begin
                  tbl_period[slot] = 0;
                  tbl_deadline[slot] = c.time_value;
               end
               issued.push_back(h);
            end
            outs.push_back(make_reply(KIND_ARM, h, h != 0, 0, 0));
         end
         CMD_CANCEL: begin
            if (c.handle_id != 0)
               for (int i = 0; i < NSLOT; i++)
                  if (!ok && tbl_handle[i] == c.handle_id) begin
                     clear_entry(i);
                     ok = 1;
                  end
            outs.push_back(make_reply(KIND_CANCEL, 0, ok, 0, 0));
         end
         CMD_TICK: begin
            if (table_running)
               for (int i = 0; i < NSLOT; i++) begin
                  if (outs.size() < MAX_RESULTS && tbl_handle[i] != 0 &&
                      tbl_deadline[i] <= c.cur_time) begin
                     outs.push_back(make_reply(KIND_FIRED, tbl_handle[i], 0, tbl_tag[i],
                                               tbl_arg[i]));
                     if (tbl_period[i] == 0) clear_entry(i);
                     else begin
                        base = tbl_deadline[i] + ((c.cur_time - tbl_deadline[i]) /
                               tbl_period[i]) * tbl_period[i];
                        tbl_deadline[i] = add_sat(base, tbl_period[i]);
                     end
                  end
               end
         end
         CMD_START: begin
            if (!table_running) begin
               for (int i = 0; i < NSLOT; i++)
                  if (tbl_handle[i] != 0 && tbl_period[i] != 0 && tbl_deadline[i] == 0)
                     tbl_deadline[i] = add_sat(c.cur_time, tbl_period[i]);
               table_running = 1;
            end
            outs.push_back(make_reply(KIND_ACK, 0, 0, 0, 0));
         end
         CMD_STOP: begin
            table_running = 0;
            outs.push_back(make_reply(KIND_ACK, 0, 0, 0, 0));
         end
         default: ;
      endcase
      if (outs.size() > 0) outs[outs.size() - 1].last = 1;
      foreach (outs[k]) expected_replies.push_back(outs[k]);
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // driver: one word offered at a time, payload held while stalled
   bit offering = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (!offering && !hold_sender && pending_cmds.size() > 0 &&
             $urandom_range(99) >= idle_pct) begin
            command_type c;
            c = pending_cmds.pop_front();
            req_cmd <= c.cmd;
            req_time_value <= c.time_value;
            req_handle_id <= c.handle_id;
            req_cur_time <= c.cur_time;
            req_callback_tag <= c.tag;
            req_callback_arg <= c.arg;
            offering = 1;
         end
         req_valid <= offering;
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // prediction happens at acceptance so it follows the accepted order
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         command_type c;
         c = {req_cmd, req_time_value, req_handle_id, req_cur_time, req_callback_tag,
              req_callback_arg};
         predict_replies(c);
         offering = 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected word kind=%0d handle=%0d", rsp_reply_kind, rsp_handle_out);
            error_count++;
         end else begin
            reply_type e;
            e = expected_replies.pop_front();
            if (rsp_reply_kind !== e.kind) begin
               $error("reply_kind exp %0d got %0d", e.kind, rsp_reply_kind); error_count++;
            end
            if (rsp_handle_out !== e.handle) begin
               $error("handle_out exp %0h got %0h", e.handle, rsp_handle_out); error_count++;
            end
            if (rsp_success !== e.success) begin
               $error("success exp %0d got %0d", e.success, rsp_success); error_count++;
            end
            if (rsp_fired_tag !== e.tag) begin
               $error("fired_tag exp %0h got %0h", e.tag, rsp_fired_tag); error_count++;
            end
            if (rsp_fired_arg !== e.arg) begin
               $error("fired_arg exp %0h got %0h", e.arg, rsp_fired_arg); error_count++;
            end
            if (rsp_last_of_run !== e.last) begin
               $error("last_of_run exp %0d got %0d", e.last, rsp_last_of_run);
               error_count++;
            end
         end
      end
   end

   function automatic command_type mk(logic [2:0] cmd, logic [63:0] tv, logic [31:0] hid,
                                      logic [63:0] now, logic [31:0] tag, logic [31:0] arg);
      command_type c;
      c.cmd = cmd; c.time_value = tv; c.handle_id = hid; c.cur_time = now;
      c.tag = tag; c.arg = arg;
      return c;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic drain();
      while (pending_cmds.size() > 0 || offering || req_valid) @(posedge clock);
      while (expected_replies.size() > 0) @(posedge clock);
   endtask

   initial begin
      logic [63:0] clk_now;
      logic [31:0] h;
      int r;
      req_valid = 0; rsp_stall = 0; req_cmd = 0; req_time_value = 0;
      req_handle_id = 0; req_cur_time = 0; req_callback_tag = 0; req_callback_arg = 0;
      for (int i = 0; i < NSLOT; i++) clear_entry(i);
      next_handle = 1;
      table_running = 0;
      reset = 1;
      repeat (4) @(posedge clock);
      @(negedge clock) reset = 0;

      // directed: rejected arms, pended recurring, saturation, full table, odd commands
      pending_cmds.push_back(mk(CMD_TICK, 0, 0, U64_MAX, 0, 0));
      pending_cmds.push_back(mk(CMD_ARM_ONE, 5, 0, 0, 0, 1));
      pending_cmds.push_back(mk(CMD_ARM_REC, 0, 0, 0, 7, 1));
      pending_cmds.push_back(mk(CMD_ARM_REC, 10, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_cmds.push_back(mk(CMD_ARM_REC, U64_MAX, 0, 0, 3, 0));
      pending_cmds.push_back(mk(CMD_ARM_ONE, 0, 0, 0, 1, 2));
      pending_cmds.push_back(mk(CMD_STOP, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_START, 0, 0, 100, 0, 0));
      pending_cmds.push_back(mk(CMD_START, 0, 0, 200, 0, 0));
      pending_cmds.push_back(mk(CMD_TICK, 0, 0, 1000, 0, 0));
      pending_cmds.push_back(mk(3'd6, U64_MAX, 32'hFFFF_FFFF, U64_MAX, 1, 1));
      pending_cmds.push_back(mk(3'd7, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_CANCEL, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_CANCEL, 0, 32'hFFFF_FFFF, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_CANCEL, 0, 1, 0, 0, 0));
      for (int i = 0; i < 17; i++)
         pending_cmds.push_back(mk(CMD_ARM_ONE, U64_MAX - 1, 0, 0, i + 1, i));
      pending_cmds.push_back(mk(CMD_TICK, 0, 0, U64_MAX, 0, 0));
      pending_cmds.push_back(mk(CMD_STOP, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk(CMD_STOP, 0, 0, 0, 0, 0));
      drain();

      // pause until everything is out, then random commands with a stretch of no idling
      hold_sender = 1;
      drain();
      repeat (100) @(posedge clock);
      hold_sender = 0;

      clk_now = 0;
      for (int n = 0; n < 250; n++) begin
         if (n == 60) begin
            drain();
            idle_pct = 0;
         end
         if (n == 110) begin
            drain();
            idle_pct = 33;
         end
         if ($urandom_range(19) == 0) clk_now = rand64();
         else clk_now = clk_now + $urandom_range(40);
         r = $urandom_range(99);
         if (r < 25)
            pending_cmds.push_back(mk(CMD_ARM_ONE, ($urandom_range(9) == 0) ? rand64() :
               clk_now + $urandom_range(60), rand64(), rand64(),
               ($urandom_range(15) == 0) ? 0 : $urandom(), $urandom()));
         else if (r < 42)
            pending_cmds.push_back(mk(CMD_ARM_REC, ($urandom_range(9) == 0) ? rand64() :
               $urandom_range(30), rand64(), clk_now,
               ($urandom_range(15) == 0) ? 0 : $urandom(), $urandom()));
         else if (r < 57) begin
            h = (issued.size() > 0 && $urandom_range(3) != 0) ?
                issued[$urandom_range(issued.size() - 1)] : $urandom();
            pending_cmds.push_back(mk(CMD_CANCEL, rand64(), h, rand64(), $urandom(),
                                      $urandom()));
         end else if (r < 85)
            pending_cmds.push_back(mk(CMD_TICK, rand64(), $urandom(), clk_now, $urandom(),
                                      $urandom()));
         else if (r < 93)
            pending_cmds.push_back(mk(CMD_START, rand64(), $urandom(), clk_now, $urandom(),
                                      $urandom()));
         else if (r < 98)
            pending_cmds.push_back(mk(CMD_STOP, rand64(), $urandom(), rand64(), $urandom(),
                                      $urandom()));
         else
            pending_cmds.push_back(mk(3'd6 + $urandom_range(1), rand64(), $urandom(),
                                      rand64(), $urandom(), $urandom()));
      end
      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_replies.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #40ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
